// File: rtl/avr_pkg.sv
// Shared constants and types for the axis-angle vector rotation core.
// No dependencies; imported by every module of the block.
package avr_pkg;

  // Default depth of the quarter-wave sine table
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;

  // One full turn in Q10.6 degrees
  localparam int ANGLE_FULL = 23040;

  // pi/2 in Q30, seed of the table generator
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Phase math: the reduced angle times the depth fits this width for depths up to 4096
  localparam int unsigned PH_NW = 27;

  // Divide by 45 through a reciprocal, exact for operands below 2**PH_NW
  localparam int unsigned DIV45        = 45;
  localparam logic [27:0] DIV45_MUL    = 28'd190887436;
  localparam int unsigned DIV45_SHIFT  = 33;
  // Fraction of a 45th, exact for operands below 2**15
  localparam logic [15:0] FRAC45_MUL   = 16'd46604;
  localparam int unsigned FRAC45_SHIFT = 21;

  // Sine and cosine, signed Q1.16
  typedef logic signed [17:0] trig_t;
  // Matrix element, signed Q24
  typedef logic signed [31:0] coef_t;

  // Side data that travels beside the phase, trig and matrix stages
  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } item_t;

endpackage

// File: rtl/avr_phase.sv
// Angle reduction and table phase: three register stages.
// Depends on avr_pkg.
module avr_phase import avr_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(4 * SINE_TABLE_DEPTH),
  localparam int unsigned UW = IW + 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [15:0]  angle_deg_i,
  output logic                vld_o,
  output logic [IW-1:0]       idx_s_o,
  output logic [IW-1:0]       idx_c_o,
  output logic [15:0]         frac_o
);

  logic [14:0]      ang_red;
  logic [PH_NW-1:0] n_d, n_q, n2_q;
  logic [54:0]      div_prod;
  logic [UW-1:0]    u_d, u_q;
  logic [5:0]       rem45;
  logic [30:0]      frac_prod;
  logic [8:0]       frac_lo;
  logic [IW-1:0]    idx_s_d, idx_c_d;
  logic [2:0]       vld_q;

  // Reduce the angle into one turn
  always_comb begin
    if (int'(angle_deg_i) < -ANGLE_FULL) begin
      ang_red = 15'(int'(angle_deg_i) + 2 * ANGLE_FULL);
    end else if (angle_deg_i < 0) begin
      ang_red = 15'(int'(angle_deg_i) + ANGLE_FULL);
    end else if (int'(angle_deg_i) >= ANGLE_FULL) begin
      ang_red = 15'(int'(angle_deg_i) - ANGLE_FULL);
    end else begin
      ang_red = 15'(angle_deg_i);
    end
    n_d = PH_NW'(ang_red) * PH_NW'(SINE_TABLE_DEPTH);
  end

  // Quotient by 45 through the reciprocal
  assign div_prod = 55'(n_q) * 55'(DIV45_MUL);
  assign u_d      = div_prod[DIV45_SHIFT +: UW];

  // Remainder sets the low fraction bits
  always_comb begin
    rem45     = 6'(n2_q - PH_NW'(u_q) * PH_NW'(DIV45));
    frac_prod = 31'({rem45, 9'b0}) * 31'(FRAC45_MUL);
    frac_lo   = frac_prod[FRAC45_SHIFT +: 9];
    idx_s_d   = u_q[UW-1:7];
    if (idx_s_d >= IW'(3 * SINE_TABLE_DEPTH)) begin
      idx_c_d = idx_s_d - IW'(3 * SINE_TABLE_DEPTH);
    end else begin
      idx_c_d = idx_s_d + IW'(SINE_TABLE_DEPTH);
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q     <= n_d;
      n2_q    <= n_q;
      u_q     <= u_d;
      idx_s_o <= idx_s_d;
      idx_c_o <= idx_c_d;
      frac_o  <= {u_q[6:0], frac_lo};
    end
  end

  assign vld_o = vld_q[2];

endmodule

// File: rtl/avr_trig.sv
// Sine and cosine from a quarter-wave table with linear interpolation.
// Two register stages; depends on avr_pkg.
module avr_trig import avr_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  localparam int unsigned IW = $clog2(4 * SINE_TABLE_DEPTH),
  localparam int unsigned TW = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [IW-1:0] idx_s_i,
  input  logic [IW-1:0] idx_c_i,
  input  logic [15:0]   frac_i,
  output logic          vld_o,
  output trig_t         sin_o,
  output trig_t         cos_o
);

  // Quarter-wave entry r, unsigned Q1.16, from a Q30 Taylor series
  function automatic logic [16:0] quarter_entry(input int unsigned r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (PI_HALF_Q30 * 64'(r)) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd8192) >>> 14;
    if (sum > 64'sd65536) begin
      sum = 64'sd65536;
    end
    return 17'(sum);
  endfunction

  logic [16:0] qtab [0:SINE_TABLE_DEPTH];

  // Build the constant table
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
    assign qtab[g] = quarter_entry(g);
  end

  // Full-wave sample by quadrant symmetry
  function automatic trig_t wave_sample(input logic [IW-1:0] n);
    logic [1:0]    q;
    logic [IW-1:0] base;
    logic [TW-1:0] r;
    logic [TW-1:0] ti;
    logic [16:0]   e;
    if (n < IW'(SINE_TABLE_DEPTH)) begin
      q = 2'd0; base = '0;
    end else if (n < IW'(2 * SINE_TABLE_DEPTH)) begin
      q = 2'd1; base = IW'(SINE_TABLE_DEPTH);
    end else if (n < IW'(3 * SINE_TABLE_DEPTH)) begin
      q = 2'd2; base = IW'(2 * SINE_TABLE_DEPTH);
    end else begin
      q = 2'd3; base = IW'(3 * SINE_TABLE_DEPTH);
    end
    r  = TW'(n - base);
    ti = q[0] ? TW'(SINE_TABLE_DEPTH) - r : r;
    e  = qtab[ti];
    return q[1] ? -$signed({1'b0, e}) : $signed({1'b0, e});
  endfunction

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] n);
    return (n == IW'(4 * SINE_TABLE_DEPTH - 1)) ? '0 : n + 1'b1;
  endfunction

  trig_t              s0_q, s1_q, c0_q, c1_q;
  logic [15:0]        frac_q;
  logic signed [18:0] ds, dc;
  logic signed [35:0] ps, pc;
  trig_t              sin_d, cos_d;
  logic [1:0]         vld_q;

  // Interpolate between neighboring samples
  always_comb begin
    ds    = 19'(s1_q) - 19'(s0_q);
    dc    = 19'(c1_q) - 19'(c0_q);
    ps    = 36'(ds) * $signed({1'b0, frac_q});
    pc    = 36'(dc) * $signed({1'b0, frac_q});
    sin_d = s0_q + 18'(ps >>> 16);
    cos_d = c0_q + 18'(pc >>> 16);
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  // Look up samples, then hold the interpolated values
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q   <= wave_sample(idx_s_i);
      s1_q   <= wave_sample(next_idx(idx_s_i));
      c0_q   <= wave_sample(idx_c_i);
      c1_q   <= wave_sample(next_idx(idx_c_i));
      frac_q <= frac_i;
      sin_o  <= sin_d;
      cos_o  <= cos_d;
    end
  end

  assign vld_o = vld_q[1];

endmodule

// File: rtl/avr_matrix.sv
// Rotation matrix elements in Q24 from sine, cosine and axis.
// Two register stages; depends on avr_pkg.
module avr_matrix import avr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  trig_t              sin_i,
  input  trig_t              cos_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               vld_o,
  output coef_t              m_o [9]
);

  // Round Q44 to nearest Q24, ties upward
  function automatic coef_t to_q24(input logic signed [55:0] v);
    logic signed [55:0] w;
    w = (v + 56'sd524288) >>> 20;
    return 32'(w);
  endfunction

  logic signed [31:0] pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q;
  logic signed [33:0] xs_q, ys_q, zs_q;
  logic signed [18:0] t_q;
  trig_t              c_q;
  logic signed [55:0] txx, tyy, tzz, txy, txz, tyz, ccw, xsw, ysw, zsw;
  coef_t              m_d [9];
  logic [1:0]         vld_q;

  // Combine products into the nine elements
  always_comb begin
    txx = 56'(t_q) * 56'(pxx_q);
    tyy = 56'(t_q) * 56'(pyy_q);
    tzz = 56'(t_q) * 56'(pzz_q);
    txy = 56'(t_q) * 56'(pxy_q);
    txz = 56'(t_q) * 56'(pxz_q);
    tyz = 56'(t_q) * 56'(pyz_q);
    ccw = 56'(c_q) <<< 28;
    xsw = 56'(xs_q) <<< 14;
    ysw = 56'(ys_q) <<< 14;
    zsw = 56'(zs_q) <<< 14;
    m_d[0] = to_q24(ccw + txx);
    m_d[1] = to_q24(txy - zsw);
    m_d[2] = to_q24(txz + ysw);
    m_d[3] = to_q24(txy + zsw);
    m_d[4] = to_q24(ccw + tyy);
    m_d[5] = to_q24(tyz - xsw);
    m_d[6] = to_q24(txz - ysw);
    m_d[7] = to_q24(tyz + xsw);
    m_d[8] = to_q24(ccw + tzz);
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  // Axis products first, then the elements
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxx_q <= axis_x_i * axis_x_i;
      pyy_q <= axis_y_i * axis_y_i;
      pzz_q <= axis_z_i * axis_z_i;
      pxy_q <= axis_x_i * axis_y_i;
      pxz_q <= axis_x_i * axis_z_i;
      pyz_q <= axis_y_i * axis_z_i;
      xs_q  <= 34'(axis_x_i) * 34'(sin_i);
      ys_q  <= 34'(axis_y_i) * 34'(sin_i);
      zs_q  <= 34'(axis_z_i) * 34'(sin_i);
      t_q   <= 19'sd65536 - 19'(cos_i);
      c_q   <= cos_i;
      m_o   <= m_d;
    end
  end

  assign vld_o = vld_q[1];

endmodule

// File: rtl/avr_apply.sv
// Matrix times vector, rounding and saturation into the output register.
// Two register stages; depends on avr_pkg.
module avr_apply import avr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  coef_t              m_i [9],
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               vld_o,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o
);

  // Round Q40 to Q16, ties upward, then saturate
  function automatic logic signed [31:0] finish(input logic signed [65:0] acc);
    logic signed [65:0] r;
    r = (acc + 66'sd8388608) >>> 24;
    if (r > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(r);
  endfunction

  logic signed [63:0] p_q [9];
  logic [1:0]         vld_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  // Products, then sums into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        p_q[3*k]   <= m_i[3*k]   * vec_x_i;
        p_q[3*k+1] <= m_i[3*k+1] * vec_y_i;
        p_q[3*k+2] <= m_i[3*k+2] * vec_z_i;
      end
      rot_x_o <= finish(66'(p_q[0]) + 66'(p_q[1]) + 66'(p_q[2]));
      rot_y_o <= finish(66'(p_q[3]) + 66'(p_q[4]) + 66'(p_q[5]));
      rot_z_o <= finish(66'(p_q[6]) + 66'(p_q[7]) + 66'(p_q[8]));
    end
  end

  assign vld_o = vld_q[1];

endmodule

// File: rtl/axis_angle_vector_rotate_core.sv
// Channel  Handshake                 Payload
// input    in_valid_i / in_ready_o   angle_deg_i, axis_{x,y,z}_i, vec_{x,y,z}_i
// output   out_valid_o / out_ready_i rot_{x,y,z}_o
//
// One request enters per cycle unless a waiting result stalls the pipe.
// The nine stages are phase (3), trig table and interpolation (2), matrix (2)
// and multiply-accumulate (2), the last being the output register.
// All stages advance together; a waiting result stalls the whole pipe.
// Reset clears the valid bits only.
// Depends on avr_pkg, avr_phase, avr_trig, avr_matrix and avr_apply.
module axis_angle_vector_rotate_core import avr_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] angle_deg_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o
);

  localparam int unsigned IW = $clog2(4 * SINE_TABLE_DEPTH);

  logic          en;
  logic          ph_vld, tr_vld, mx_vld;
  logic [IW-1:0] idx_s, idx_c;
  logic [15:0]   frac;
  trig_t         sin_v, cos_v;
  coef_t         m [9];
  item_t         side_q [7];

  // Advance when the output register is free or being drained
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Carry axis and vector beside the phase, trig and matrix stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{axis_x: axis_x_i, axis_y: axis_y_i, axis_z: axis_z_i,
                     vec_x: vec_x_i, vec_y: vec_y_i, vec_z: vec_z_i};
      for (int k = 1; k < 7; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  avr_phase #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_phase (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .angle_deg_i,
    .vld_o(ph_vld), .idx_s_o(idx_s), .idx_c_o(idx_c), .frac_o(frac)
  );

  avr_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_trig (
    .clk_i, .rst_ni, .en_i(en), .vld_i(ph_vld), .idx_s_i(idx_s), .idx_c_i(idx_c),
    .frac_i(frac), .vld_o(tr_vld), .sin_o(sin_v), .cos_o(cos_v)
  );

  avr_matrix u_matrix (
    .clk_i, .rst_ni, .en_i(en), .vld_i(tr_vld), .sin_i(sin_v), .cos_i(cos_v),
    .axis_x_i(side_q[4].axis_x), .axis_y_i(side_q[4].axis_y),
    .axis_z_i(side_q[4].axis_z), .vld_o(mx_vld), .m_o(m)
  );

  avr_apply u_apply (
    .clk_i, .rst_ni, .en_i(en), .vld_i(mx_vld), .m_i(m),
    .vec_x_i(side_q[6].vec_x), .vec_y_i(side_q[6].vec_y), .vec_z_i(side_q[6].vec_z),
    .vld_o(out_valid_o), .rot_x_o, .rot_y_o, .rot_z_o
  );

  // Interpolated sine and cosine never leave the unit range
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_vld |-> (sin_v <= 18'sd65536 && sin_v >= -18'sd65536 &&
                cos_v <= 18'sd65536 && cos_v >= -18'sd65536))
    else $error("sine or cosine out of range");

  // A result is dropped only after it was taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result lost");

  // A stall freezes the inner valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(ph_vld) && $stable(tr_vld) && $stable(mx_vld)))
    else $error("pipeline moved during stall");

endmodule
